### rtl/ordered_multiset_rank_select_defines.svh
// Assertion macros used by the checker file of the multiset block.
// Depends on nothing.
`ifndef ORDERED_MULTISET_RANK_SELECT_DEFINES_SVH
`define ORDERED_MULTISET_RANK_SELECT_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define OMRS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define OMRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/omrs_pkg.sv
// Types and operation codes of the ordered multiset block.
// Depends on nothing.
`default_nettype none
package omrs_pkg;
  typedef enum logic [2:0] {
    OP_INSERT = 3'd0, OP_DELETE = 3'd1, OP_FIND = 3'd2, OP_LOWER = 3'd3,
    OP_UPPER = 3'd4, OP_PRED = 3'd5, OP_SELECT = 3'd6, OP_RANK = 3'd7
  } op_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] key;
    logic [7:0]         position;
  } request_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] result_key;
    logic [8:0]         rank_value;
    logic [7:0]         entry_count;
    logic               full_res;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_FETCH, ST_SHIFT, ST_WRITE, ST_DONE
  } state_t;
endpackage
`default_nettype wire

### rtl/ordered_multiset_rank_select.sv
// Top level of the ordered multiset: sorted key memory, scan sequencer.
// Depends on omrs_pkg.
//
// channel  | signals                  | handshake
// request  | start, busy, req         | taken when start && !busy
// result   | done, res                | one-cycle strobe, no stall
//
// Count pass over the one-read one-write key memory: every held entry is read
// and compared with the key. Insert or delete then moves entries one at a time,
// each through a read (SHIFT) and a write (WRITE); located queries add a fetch
// (FETCH, WRITE) of the entry found. The result is then posted and done strobes.
// busy holds through the strobe. Reset empties the store (count cleared); memory
// contents are not cleared. The receiver cannot stall.
`default_nettype none
module ordered_multiset_rank_select
  import omrs_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire request_t req,
  output logic          busy,
  output logic          done,
  output result_t       res
);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic signed [31:0] mem [CAPACITY];
  logic signed [31:0] rd_data;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic               wr_en;
  logic signed [31:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  state_t state, state_next;
  request_t cur;
  logic [7:0] held;
  logic [8:0] idx;    // scan / shift index
  logic [8:0] lt, le;
  logic       rd_pend;

  // memory address from the scan/shift counter, or for a fetch from lt, le or the select position
  logic [8:0] fetch_idx;
  logic       is_ins;
  assign is_ins = (cur.operation == OP_INSERT);

  always_comb begin
    fetch_idx = idx;
    case (cur.operation)
      OP_LOWER:  fetch_idx = lt;
      OP_UPPER:  fetch_idx = le;
      OP_PRED:   fetch_idx = lt - 9'd1;
      OP_SELECT: fetch_idx = {1'b0, cur.position} - 9'd1;
      default:   fetch_idx = idx;
    endcase
  end

  always_comb begin
    rd_addr = idx[AW-1:0];
    if (state == ST_FETCH) rd_addr = fetch_idx[AW-1:0];
    else if (state == ST_SHIFT && is_ins) rd_addr = idx[AW-1:0] - AW'(1);
    else if (state == ST_SHIFT) rd_addr = idx[AW-1:0] + AW'(1);
  end

  logic ins_ok, del_ok;
  assign ins_ok = ({1'b0, held} < 9'(CAPACITY));
  assign del_ok = (le > lt);

  logic take;
  assign take = start && !busy;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (take) state_next = ST_SCAN;
      ST_SCAN:
        if (idx >= {1'b0, held} && !rd_pend) begin
          case (cur.operation)
            OP_INSERT: state_next = ins_ok ? ST_SHIFT : ST_DONE;
            OP_DELETE: state_next = del_ok ? ST_SHIFT : ST_DONE;
            OP_LOWER, OP_UPPER, OP_PRED, OP_SELECT: state_next = ST_FETCH;
            default: state_next = ST_DONE;
          endcase
        end
      ST_FETCH: state_next = ST_WRITE;
      ST_SHIFT:
        if (is_ins ? (idx <= le) : (idx + 9'd1 >= {1'b0, held}))
          state_next = ST_DONE;
        else state_next = ST_WRITE;
      ST_WRITE: state_next = (cur.operation == OP_INSERT ||
                              cur.operation == OP_DELETE) ? ST_SHIFT : ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    wr_en = 1'b0;
    wr_addr = idx[AW-1:0];
    wr_data = rd_data;
    if (state == ST_WRITE && (is_ins || cur.operation == OP_DELETE))
      wr_en = 1'b1;
    if (state == ST_SHIFT && is_ins && idx <= le) begin
      wr_en = 1'b1;
      wr_data = cur.key;
    end
  end

  // result fields
  logic found_w;
  always_comb begin
    case (cur.operation)
      OP_LOWER:  found_w = (lt < {1'b0, held});
      OP_UPPER:  found_w = (le < {1'b0, held});
      OP_PRED:   found_w = (lt != 9'd0);
      OP_SELECT: found_w = (cur.position != 8'd0) && (cur.position <= held);
      default:   found_w = 1'b0;
    endcase
  end

  logic signed [31:0] cmp_key;
  assign cmp_key = rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      held <= '0;
      rd_pend <= 1'b0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= (state == ST_DONE);
      case (state)
        ST_IDLE: if (take) begin
          cur <= req;
          idx <= '0;
          lt <= '0;
          le <= '0;
          rd_pend <= 1'b0;
          res <= '0;
        end
        ST_SCAN: begin
          if (rd_pend) begin
            if (cmp_key < cur.key) lt <= lt + 9'd1;
            if (cmp_key <= cur.key) le <= le + 9'd1;
          end
          rd_pend <= (idx < {1'b0, held});
          if (idx < {1'b0, held}) idx <= idx + 9'd1;
          if (state_next == ST_SHIFT) idx <= is_ins ? {1'b0, held} : lt;
          if (state_next == ST_DONE) begin
            res.entry_count <= held;
            res.full_res <= !ins_ok;
            if (cur.operation == OP_FIND && del_ok) begin
              res.found <= 1'b1;
              res.result_key <= cur.key;
            end
            if (cur.operation == OP_RANK) begin
              res.found <= 1'b1;
              res.rank_value <= lt + 9'd1;
            end
          end
        end
        ST_FETCH: ;
        ST_WRITE: begin
          if (!is_ins && cur.operation != OP_DELETE) begin
            res.found <= found_w;
            res.result_key <= found_w ? rd_data : 32'sd0;
            res.entry_count <= held;
            res.full_res <= !ins_ok;
          end
          if (is_ins) idx <= idx - 9'd1;
          else if (cur.operation == OP_DELETE) idx <= idx + 9'd1;
        end
        ST_SHIFT: if (state_next == ST_DONE) begin
          res.found <= 1'b1;
          res.result_key <= cur.key;
          if (is_ins) begin
            held <= held + 8'd1;
            res.entry_count <= held + 8'd1;
            res.full_res <= ({1'b0, held} + 9'd1 >= 9'(CAPACITY));
          end else begin
            held <= held - 8'd1;
            res.entry_count <= held - 8'd1;
            res.full_res <= 1'b0;
          end
        end
        ST_DONE: ;
        default: ;
      endcase
    end
  end

  assign busy = (state != ST_IDLE) || done;
endmodule
`default_nettype wire

### rtl/omrs_checker.sv
// Port-level checks of the ordered multiset block, bound to the top level.
// Depends on omrs_pkg and the assertion macros header.
`default_nettype none
`include "ordered_multiset_rank_select_defines.svh"
module omrs_checker
  import omrs_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    start,
  input wire logic    busy,
  input wire logic    done,
  input wire result_t res
);
  `OMRS_ASSERT_NEXT(a_take_busy, clk, rst, start && !busy, busy)
  `OMRS_ASSERT_IMP(a_done_busy, clk, rst, done, busy)
  `OMRS_ASSERT_NEXT(a_done_once, clk, rst, done, !done)
  `OMRS_ASSERT_IMP(a_nf_zero, clk, rst, done && !res.found, res.result_key == 32'sd0)
endmodule

bind ordered_multiset_rank_select omrs_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .res(res)
);
`default_nettype wire
